FILE: rtl/lrrb_pkg.sv
// Shared types, constants and codes for the line-aware receive ring buffer.
// No dependencies; the top level refers to this package by scoped names.
package lrrb_pkg;

	// Default sizing, handed to the top-level parameters
	localparam int DEPTH_DEF    = 64;
	localparam int PORTS_DEF    = 2;
	localparam int MAX_LINE_DEF = 64;

	// Line counts run wider than the 6-bit result field; a terminator change can
	// leave more lines counted than bytes held
	localparam int LCNT_W = 16;

	// Configuration port
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam logic [1:0] REG_TERM = 2'd0;
	localparam logic [1:0] REG_LIM0 = 2'd1;
	localparam logic [1:0] REG_LIM1 = 2'd2;

	localparam logic [7:0] TERM_RST  = 8'd10;
	localparam logic [5:0] LIMIT_RST = 6'd48;

	// Operation codes (codes 5..7 are no-ops that still give one beat)
	localparam logic [2:0] OP_RX    = 3'd0;
	localparam logic [2:0] OP_READ  = 3'd1;
	localparam logic [2:0] OP_PEEK  = 3'd2;
	localparam logic [2:0] OP_LINE  = 3'd3;
	localparam logic [2:0] OP_FLUSH = 3'd4;

	// Input item
	typedef struct packed {
		logic [2:0] op;
		logic       port;
		logic [7:0] rx_data;
		logic [6:0] max_len;
	} item_t;

	// Result beat
	typedef struct packed {
		logic [7:0] data;
		logic       data_valid;
		logic [5:0] fill_count;
		logic [5:0] line_count;
		logic       notify;
		logic       dropped;
		logic       line_complete;
		logic       last;
	} result_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FETCH,
		ST_READ,
		ST_POP,
		ST_FILL,
		ST_EMIT
	} state_t;

endpackage

FILE: rtl/lrrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lrrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/lrrb_cnt.sv
// Shared pointer/count update unit: one push or one pop of a ring per use.
// No package dependencies; sized by the ring depth and the line count width.
module lrrb_cnt #(
	parameter int DEPTH = 64,
	parameter int LW    = 16
) (
	input  logic                     push,
	input  logic [$clog2(DEPTH)-1:0] held_in,
	input  logic [LW-1:0]            lines_in,
	input  logic [$clog2(DEPTH)-1:0] ptr_in,
	input  logic [7:0]               byte_in,
	input  logic [7:0]               term,
	output logic [$clog2(DEPTH)-1:0] held_out,
	output logic [LW-1:0]            lines_out,
	output logic [$clog2(DEPTH)-1:0] ptr_out,
	output logic                     is_term
);

	localparam int HW = $clog2(DEPTH);
	localparam logic [HW-1:0] PTR_LAST = HW'(DEPTH - 1);

	assign is_term = (byte_in == term);

	// pointer advance with wrap at the ring depth
	assign ptr_out = (ptr_in == PTR_LAST) ? '0 : ptr_in + HW'(1);

	// held count: one adder, +1 on push, -1 on pop
	assign held_out = push ? held_in + HW'(1) : held_in - HW'(1);

	// line count: count terminators in, saturate going out, clear on empty
	always_comb begin
		lines_out = lines_in;
		if (push) begin
			if (is_term) begin
				lines_out = lines_in + LW'(1);
			end
		end else begin
			if (is_term && lines_in != '0) begin
				lines_out = lines_in - LW'(1);
			end
			if (held_out == '0) begin
				lines_out = '0;
			end
		end
	end

endmodule

FILE: rtl/line_aware_rx_ring_buffer.sv
// Top level: per-port line-aware receive rings, sequencer, APB register file.
// Depends on lrrb_pkg, lrrb_ram (ring store and line buffer), lrrb_cnt (update unit).
//
// One item at a time: an item is taken when start is high and busy is low, and
// busy stays high until its last result beat has been issued. Result beats come
// one per cycle on result, marked by result_valid, and cannot be held off.
// Steps per item, set by the sequencer and the registered ring read port:
// rx_byte, flush and unknown ops execute and answer; read and peek fetch, then
// read; read_line with no complete line answers at the fetch; otherwise it pops
// its bytes through the shared update unit into a line buffer, then emits them,
// since every beat reports the counts as they stand after the whole line is out.
module line_aware_rx_ring_buffer #(
	parameter int DEPTH    = lrrb_pkg::DEPTH_DEF,
	parameter int PORTS    = lrrb_pkg::PORTS_DEF,
	parameter int MAX_LINE = lrrb_pkg::MAX_LINE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// item channel
	input  logic                          start,
	output logic                          busy,
	input  lrrb_pkg::item_t               item,
	// result channel
	output logic                          result_valid,
	output lrrb_pkg::result_t             result,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lrrb_pkg::PADDR_W-1:0]  paddr,
	input  logic [lrrb_pkg::PDATA_W-1:0]  pwdata,
	output logic [lrrb_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	localparam int HW  = $clog2(DEPTH);
	localparam int CW  = HW + 6;
	localparam int LW  = lrrb_pkg::LCNT_W;
	localparam int PW  = (PORTS > 1) ? $clog2(PORTS) : 1;
	localparam int RD  = PORTS * DEPTH;
	localparam int RAW = $clog2(RD);
	localparam int LBW = $clog2(MAX_LINE);
	localparam logic [HW-1:0] HELD_FULL = HW'(DEPTH - 1);
	localparam logic [6:0]    ML_MAX    = 7'(MAX_LINE);
	localparam logic [6:0]    ML_MIN    = 7'd2;

	// ------------------------------------------------------------------
	// helpers
	function automatic logic [5:0] cnt6(input logic [HW-1:0] v);
		logic [HW+5:0] w;
		w = {6'b0, v};
		return w[5:0];
	endfunction

	function automatic logic [RAW-1:0] ring_addr(input logic [PW-1:0] p,
		input logic [HW-1:0] ptr);
		return RAW'(int'(p) * DEPTH + int'(ptr));
	endfunction

	// ------------------------------------------------------------------
	// configuration registers
	logic [7:0] term_q;
	logic [5:0] lim0_q;
	logic [5:0] lim1_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q <= lrrb_pkg::TERM_RST;
			lim0_q <= lrrb_pkg::LIMIT_RST;
			lim1_q <= lrrb_pkg::LIMIT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				lrrb_pkg::REG_TERM: term_q <= pwdata[7:0];
				lrrb_pkg::REG_LIM0: lim0_q <= pwdata[5:0];
				lrrb_pkg::REG_LIM1: lim1_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			lrrb_pkg::REG_TERM: prdata = {24'b0, term_q};
			lrrb_pkg::REG_LIM0: prdata = {26'b0, lim0_q};
			lrrb_pkg::REG_LIM1: prdata = {26'b0, lim1_q};
			default:            prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// sequencer and item registers
	lrrb_pkg::state_t state_q, state_d;
	logic [2:0]       op_q;
	logic [PW-1:0]    port_q;
	logic [7:0]       rx_q;
	logic [LBW-1:0]   cap_q;
	logic [LBW-1:0]   n_q;
	logic [LBW-1:0]   idx_q;
	logic             complete_q;
	logic             accept;
	logic [PW-1:0]    port_sel;
	logic [6:0]       ml_clamp;

	assign busy     = (state_q != lrrb_pkg::ST_IDLE);
	assign accept   = start && !busy;
	assign port_sel = (PORTS > 1) ? PW'(item.port) : '0;
	assign ml_clamp = (item.max_len > ML_MAX) ? ML_MAX :
		(item.max_len < ML_MIN) ? ML_MIN : item.max_len;

	// per-port ring state
	logic [HW-1:0] wp_q    [PORTS];
	logic [HW-1:0] rp_q    [PORTS];
	logic [HW-1:0] held_q  [PORTS];
	logic [LW-1:0] lines_q [PORTS];
	logic [HW-1:0] held_cur;
	logic [LW-1:0] lines_cur;

	assign held_cur  = held_q[port_q];
	assign lines_cur = lines_q[port_q];

	// ------------------------------------------------------------------
	// storage and shared update unit
	logic           ring_we;
	logic [RAW-1:0] ring_raddr;
	logic [7:0]     ring_rdata;
	logic           lb_we;
	logic [LBW-1:0] lb_raddr;
	logic [7:0]     lb_rdata;

	logic           cu_push;
	logic [HW-1:0]  cu_held;
	logic [LW-1:0]  cu_lines;
	logic [HW-1:0]  cu_ptr;
	logic           cu_term;

	lrrb_ram #(.WIDTH(8), .DEPTH(RD)) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_addr(port_q, wp_q[port_q])),
		.wdata (rx_q),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	lrrb_ram #(.WIDTH(8), .DEPTH(MAX_LINE)) u_line (
		.clk   (clk),
		.we    (lb_we),
		.waddr (n_q),
		.wdata (ring_rdata),
		.raddr (lb_raddr),
		.rdata (lb_rdata)
	);

	lrrb_cnt #(.DEPTH(DEPTH), .LW(LW)) u_cnt (
		.push      (cu_push),
		.held_in   (held_cur),
		.lines_in  (lines_cur),
		.ptr_in    (cu_push ? wp_q[port_q] : rp_q[port_q]),
		.byte_in   (cu_push ? rx_q : ring_rdata),
		.term      (term_q),
		.held_out  (cu_held),
		.lines_out (cu_lines),
		.ptr_out   (cu_ptr),
		.is_term   (cu_term)
	);

	// ------------------------------------------------------------------
	// decisions shared by next-state and output logic
	logic rx_full;
	logic no_line;
	logic pop_stop;
	logic emit_last;
	logic [5:0] lim_sel;

	assign rx_full   = (held_cur == HELD_FULL);
	assign no_line   = (lines_cur == '0) || (held_cur == '0);
	assign pop_stop  = cu_term || (cu_held == '0) ||
		({1'b0, n_q} + (LBW + 1)'(1) == {1'b0, cap_q});
	assign emit_last = (idx_q + LBW'(1) == n_q);
	assign lim_sel   = (port_q == '0) ? lim0_q : lim1_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lrrb_pkg::ST_IDLE: begin
				if (accept) begin
					if (item.op == lrrb_pkg::OP_READ || item.op == lrrb_pkg::OP_PEEK ||
						item.op == lrrb_pkg::OP_LINE) begin
						state_d = lrrb_pkg::ST_FETCH;
					end else begin
						state_d = lrrb_pkg::ST_EXEC;
					end
				end
			end
			lrrb_pkg::ST_EXEC:  state_d = lrrb_pkg::ST_IDLE;
			lrrb_pkg::ST_FETCH: begin
				if (op_q != lrrb_pkg::OP_LINE) begin
					state_d = lrrb_pkg::ST_READ;
				end else if (no_line) begin
					state_d = lrrb_pkg::ST_IDLE;
				end else begin
					state_d = lrrb_pkg::ST_POP;
				end
			end
			lrrb_pkg::ST_READ:  state_d = lrrb_pkg::ST_IDLE;
			lrrb_pkg::ST_POP:   state_d = pop_stop ? lrrb_pkg::ST_FILL : lrrb_pkg::ST_POP;
			lrrb_pkg::ST_FILL:  state_d = lrrb_pkg::ST_EMIT;
			lrrb_pkg::ST_EMIT:  state_d = emit_last ? lrrb_pkg::ST_IDLE : lrrb_pkg::ST_EMIT;
			default:            state_d = lrrb_pkg::ST_IDLE;
		endcase
	end

	// actions and result beat
	logic              push_en;
	logic              pop_en;
	logic              flush_en;
	logic              emit;
	lrrb_pkg::result_t res_d;

	always_comb begin
		push_en    = 1'b0;
		pop_en     = 1'b0;
		flush_en   = 1'b0;
		emit       = 1'b0;
		cu_push    = 1'b0;
		lb_we      = 1'b0;
		ring_raddr = ring_addr(port_q, rp_q[port_q]);
		lb_raddr   = '0;
		res_d      = '0;
		res_d.fill_count = cnt6(held_cur);
		res_d.line_count = lines_cur[5:0];
		res_d.last       = 1'b1;
		unique case (state_q)
			lrrb_pkg::ST_EXEC: begin
				emit = 1'b1;
				if (op_q == lrrb_pkg::OP_RX) begin
					cu_push = 1'b1;
					if (rx_full) begin
						res_d.dropped = 1'b1;
						res_d.notify  = 1'b1;
					end else begin
						push_en = 1'b1;
						res_d.fill_count = cnt6(cu_held);
						res_d.line_count = cu_lines[5:0];
						res_d.notify = cu_term || (CW'(cu_held) > CW'(lim_sel));
					end
				end else if (op_q == lrrb_pkg::OP_FLUSH) begin
					flush_en = 1'b1;
					res_d.fill_count = '0;
					res_d.line_count = '0;
				end
			end
			lrrb_pkg::ST_FETCH: begin
				// read_line with nothing complete answers at once
				emit = (op_q == lrrb_pkg::OP_LINE) && no_line;
			end
			lrrb_pkg::ST_READ: begin
				emit = 1'b1;
				if (held_cur != '0) begin
					res_d.data       = ring_rdata;
					res_d.data_valid = 1'b1;
					if (op_q == lrrb_pkg::OP_READ) begin
						pop_en = 1'b1;
						res_d.fill_count = cnt6(cu_held);
						res_d.line_count = cu_lines[5:0];
					end
				end
			end
			lrrb_pkg::ST_POP: begin
				// pop one byte a cycle; fetch the next one at the advanced pointer
				pop_en     = 1'b1;
				lb_we      = 1'b1;
				ring_raddr = ring_addr(port_q, cu_ptr);
			end
			lrrb_pkg::ST_FILL: begin
				lb_raddr = '0;
			end
			lrrb_pkg::ST_EMIT: begin
				emit     = 1'b1;
				lb_raddr = idx_q + LBW'(1);
				res_d.data          = lb_rdata;
				res_d.data_valid    = 1'b1;
				res_d.last          = emit_last;
				res_d.line_complete = emit_last && complete_q;
			end
			default: ;
		endcase
	end

	assign ring_we = push_en;

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lrrb_pkg::ST_IDLE;
			op_q       <= lrrb_pkg::OP_RX;
			port_q     <= '0;
			rx_q       <= '0;
			cap_q      <= '0;
			n_q        <= '0;
			idx_q      <= '0;
			complete_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_q       <= item.op;
				port_q     <= port_sel;
				rx_q       <= item.rx_data;
				cap_q      <= LBW'(ml_clamp - 7'd1);
				n_q        <= '0;
				idx_q      <= '0;
				complete_q <= 1'b0;
			end
			if (state_q == lrrb_pkg::ST_POP) begin
				n_q <= n_q + LBW'(1);
				if (pop_stop) begin
					complete_q <= cu_term;
				end
			end
			if (state_q == lrrb_pkg::ST_EMIT) begin
				idx_q <= idx_q + LBW'(1);
			end
		end
	end

	// per-port pointers and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PORTS; i++) begin
				wp_q[i]    <= '0;
				rp_q[i]    <= '0;
				held_q[i]  <= '0;
				lines_q[i] <= '0;
			end
		end else if (push_en) begin
			wp_q[port_q]    <= cu_ptr;
			held_q[port_q]  <= cu_held;
			lines_q[port_q] <= cu_lines;
		end else if (pop_en) begin
			rp_q[port_q]    <= cu_ptr;
			held_q[port_q]  <= cu_held;
			lines_q[port_q] <= cu_lines;
		end else if (flush_en) begin
			wp_q[port_q]    <= rp_q[port_q];
			held_q[port_q]  <= '0;
			lines_q[port_q] <= '0;
		end
	end

	// result register
	lrrb_pkg::result_t res_q;
	logic              strobe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_d;
		end
	end

	assign result_valid = strobe_q;
	assign result       = res_q;

	// ------------------------------------------------------------------
	// assertions

	// an accepted item always occupies the sequencer
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted item did not raise busy");

	// beats of one item come back to back
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |=> result_valid)
		else $error("result burst broken before last beat");

	// a ring never holds more than DEPTH-1 bytes
	a_held_max: assert property (@(posedge clk) disable iff (!arst_n)
		held_cur <= HELD_FULL)
		else $error("ring fill count beyond capacity");

	// a beat is issued only while an item is in flight
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> busy)
		else $error("result issued while idle");

endmodule
